FILE: rtl/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types for the byte deque: opcodes, status codes, FSM states and
// the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package cdq_pkg;

   typedef enum logic [2:0] {
      OP_NOP        = 3'd0,
      OP_PUSH_FRONT = 3'd1,
      OP_PUSH_BACK  = 3'd2,
      OP_POP_FRONT  = 3'd3,
      OP_POP_BACK   = 3'd4
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_UNDERFLOW = 2'd1,
      ST_OVERFLOW  = 2'd2
   } status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_RESP = 1'b1
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic       capture;     // item accepted this cycle
      logic       push_front;
      logic       push_back;
      logic       pop_front;
      logic       pop_back;
      status_type status;
      logic       respond;     // result cycle
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic empty;
      logic full;
   } dp_status_type;

endpackage

FILE: rtl/cdq_ctrl.sv
// ----------------------------------------------------------------------------
// cdq_ctrl
// Two-state controller: accepts an item, decodes it against the
// empty/full status, then presents the result in S_RESP.
// ----------------------------------------------------------------------------
module cdq_ctrl
   import cdq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [2:0]    req_opcode,
   input  dp_status_type dp_status,
   output cmd_type       cmd,
   output logic          busy
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      cmd.status = ST_OK;
      busy       = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               case (opcode_type'(req_opcode))
                  OP_PUSH_FRONT: begin
                     if (dp_status.full) cmd.status = ST_OVERFLOW;
                     else                cmd.push_front = 1'b1;
                  end
                  OP_PUSH_BACK: begin
                     if (dp_status.full) cmd.status = ST_OVERFLOW;
                     else                cmd.push_back = 1'b1;
                  end
                  OP_POP_FRONT: begin
                     if (dp_status.empty) cmd.status = ST_UNDERFLOW;
                     else                 cmd.pop_front = 1'b1;
                  end
                  OP_POP_BACK: begin
                     if (dp_status.empty) cmd.status = ST_UNDERFLOW;
                     else                 cmd.pop_back = 1'b1;
                  end
                  default: begin
                     cmd.status = ST_OK;
                  end
               endcase
            end
         end
         S_RESP: begin
            busy        = 1'b1;
            cmd.respond = 1'b1;
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

endmodule

FILE: rtl/cdq_dpath.sv
// ----------------------------------------------------------------------------
// cdq_dpath
// Deque datapath: circular buffer memory, head/tail/count registers and
// cached front/back bytes. A pop that leaves items refills the cache from the memory.
// ----------------------------------------------------------------------------
module cdq_dpath
   import cdq_pkg::*;
#(
   parameter int DEPTH = 16
)
(
   input  logic          clock,
   input  logic          reset,
   input  cmd_type       cmd,
   input  logic [7:0]    req_data_byte,
   output dp_status_type dp_status,
   output logic [7:0]    rsp_front_byte,
   output logic [7:0]    rsp_back_byte,
   output logic          rsp_is_empty,
   output logic          rsp_is_full,
   output logic [1:0]    rsp_status
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

   logic [7:0] mem [DEPTH];

   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       front_ff, front_in;
   logic [7:0]       back_ff, back_in;
   status_type       status_ff, status_in;
   logic             fix_front_ff, fix_front_in;
   logic             fix_back_ff, fix_back_in;
   logic [7:0]       rd_data_ff;

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [IDX_W-1:0] rd_addr;
   logic [IDX_W-1:0] head_inc, head_dec, tail_inc, tail_dec;
   logic             is_empty;
   logic [7:0]       front_now, back_now;

   assign head_inc = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
   assign head_dec = (head_ff == '0) ? LAST_IDX : head_ff - 1'b1;
   assign tail_inc = (tail_ff == LAST_IDX) ? '0 : tail_ff + 1'b1;
   assign tail_dec = (tail_ff == '0) ? LAST_IDX : tail_ff - 1'b1;

   assign is_empty        = (count_ff == '0);
   assign dp_status.empty = is_empty;
   assign dp_status.full  = (count_ff == FULL_CNT);

   always_comb begin
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      front_in     = front_ff;
      back_in      = back_ff;
      status_in    = status_ff;
      fix_front_in = fix_front_ff;
      fix_back_in  = fix_back_ff;
      wr_en        = 1'b0;
      wr_addr      = head_dec;
      rd_addr      = head_inc;

      if (cmd.capture) begin
         status_in    = cmd.status;
         fix_front_in = 1'b0;
         fix_back_in  = 1'b0;
      end

      if (cmd.push_front) begin
         wr_en    = 1'b1;
         wr_addr  = head_dec;
         head_in  = head_dec;
         count_in = count_ff + 1'b1;
         front_in = req_data_byte;
         if (is_empty) back_in = req_data_byte;
      end else if (cmd.push_back) begin
         wr_en    = 1'b1;
         wr_addr  = tail_inc;
         tail_in  = tail_inc;
         count_in = count_ff + 1'b1;
         back_in  = req_data_byte;
         if (is_empty) front_in = req_data_byte;
      end else if (cmd.pop_front || cmd.pop_back) begin
         count_in = count_ff - 1'b1;
         if (count_ff == ONE_CNT) begin
            // last element gone: back to the reset layout
            head_in = '0;
            tail_in = LAST_IDX;
         end else if (cmd.pop_front) begin
            rd_addr      = head_inc;
            head_in      = head_inc;
            fix_front_in = 1'b1;
         end else begin
            rd_addr     = tail_dec;
            tail_in     = tail_dec;
            fix_back_in = 1'b1;
         end
      end

      // fold the refilled byte into the cache after the result cycle
      if (cmd.respond) begin
         if (fix_front_ff) front_in = rd_data_ff;
         if (fix_back_ff)  back_in  = rd_data_ff;
         fix_front_in = 1'b0;
         fix_back_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= LAST_IDX;
         count_ff     <= '0;
         fix_front_ff <= 1'b0;
         fix_back_ff  <= 1'b0;
         status_ff    <= ST_OK;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         fix_front_ff <= fix_front_in;
         fix_back_ff  <= fix_back_in;
         status_ff    <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      front_ff <= front_in;
      back_ff  <= back_in;
   end

   // storage: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= req_data_byte;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign front_now = fix_front_ff ? rd_data_ff : front_ff;
   assign back_now  = fix_back_ff  ? rd_data_ff : back_ff;

   assign rsp_front_byte = is_empty ? 8'd0 : front_now;
   assign rsp_back_byte  = is_empty ? 8'd0 : back_now;
   assign rsp_is_empty   = is_empty;
   assign rsp_is_full    = dp_status.full;
   assign rsp_status     = status_ff;

endmodule

FILE: rtl/char_deque.sv
// ----------------------------------------------------------------------------
// char_deque
// Double-ended queue of bytes on a circular buffer of DEPTH entries.
// ----------------------------------------------------------------------------
//
//   channel   ports                               handshake
//   -------   ---------------------------------   ---------------------------
//   request   req_opcode, req_data_byte           start high, busy low
//   response  rsp_front_byte, rsp_back_byte,      rsp_valid, one cycle,
//             rsp_is_empty, rsp_is_full,          no back-pressure
//             rsp_status
//
// On the accept edge the indices are updated and the single memory access
// is issued; the next cycle shows the result (rsp_valid) with busy high,
// and no new item is taken while busy is high. The registered memory read
// refills the front or back byte after a pop.
// Reset (synchronous) empties the deque; storage itself is not cleared.
// The receiver cannot stall: a result is gone after its one valid cycle.
//
module char_deque
   import cdq_pkg::*;
#(
   parameter int DEPTH = 16
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [2:0] req_opcode,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   output logic [7:0] rsp_front_byte,
   output logic [7:0] rsp_back_byte,
   output logic       rsp_is_empty,
   output logic       rsp_is_full,
   output logic [1:0] rsp_status
);

   cmd_type       cmd;
   dp_status_type dp_status;

   // sequencing and opcode decode
   cdq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_opcode (req_opcode),
      .dp_status  (dp_status),
      .cmd        (cmd),
      .busy       (busy)
   );

   // storage, indices, cached ends
   cdq_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_data_byte  (req_data_byte),
      .dp_status      (dp_status),
      .rsp_front_byte (rsp_front_byte),
      .rsp_back_byte  (rsp_back_byte),
      .rsp_is_empty   (rsp_is_empty),
      .rsp_is_full    (rsp_is_full),
      .rsp_status     (rsp_status)
   );

   // result cycle is exactly the controller's respond cycle
   assign rsp_valid = cmd.respond;

endmodule

FILE: bench/deque_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_checker
// Watches the request and response channels of the byte deque, predicts
// every result from its own model of the buffer, and compares field by
// field.
// ----------------------------------------------------------------------------
module deque_checker
   import cdq_pkg::*;
#(
   parameter int DEPTH = 16
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic       busy,
   input  logic [2:0] req_opcode,
   input  logic [7:0] req_data_byte,
   input  logic       rsp_valid,
   input  logic [7:0] rsp_front_byte,
   input  logic [7:0] rsp_back_byte,
   input  logic       rsp_is_empty,
   input  logic       rsp_is_full,
   input  logic [1:0] rsp_status,
   output int         fail_count,
   output int         pending,
   output int         items_seen,
   output int         results_seen,
   output int         overflow_seen,
   output int         underflow_seen,
   output int         full_seen,
   output int         empty_seen
);

   typedef struct {
      logic [7:0] front;
      logic [7:0] back;
      logic       empty;
      logic       full;
      status_type status;
   } deque_view_type;

   // counters start at zero; the model is cleared while reset is high
   logic [7:0]     model_mem [DEPTH];
   int             model_head;
   int             model_fill;
   deque_view_type expected_views [$];

   // apply one item to the model, return the view after it
   function automatic deque_view_type apply_deque_op(input logic [2:0] op,
                                                     input logic [7:0] data);
      deque_view_type v;
      v.status = ST_OK;
      case (op)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (model_fill == DEPTH) begin
               v.status = ST_OVERFLOW;
            end else if (op == OP_PUSH_FRONT) begin
               model_head = (model_head == 0) ? DEPTH - 1 : model_head - 1;
               model_mem[model_head] = data;
               model_fill++;
            end else begin
               model_mem[(model_head + model_fill) % DEPTH] = data;
               model_fill++;
            end
         end
         OP_POP_FRONT, OP_POP_BACK: begin
            if (model_fill == 0) begin
               v.status = ST_UNDERFLOW;
            end else begin
               if (op == OP_POP_FRONT) model_head = (model_head + 1) % DEPTH;
               model_fill--;
               if (model_fill == 0) model_head = 0;
            end
         end
         default: ;
      endcase
      v.empty = (model_fill == 0);
      v.full  = (model_fill == DEPTH);
      v.front = v.empty ? 8'h00 : model_mem[model_head];
      v.back  = v.empty ? 8'h00 : model_mem[(model_head + model_fill - 1) % DEPTH];
      return v;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("[%0t] mismatch on result %0d, %s: got 0x%0h, expected 0x%0h",
               $realtime, results_seen, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      deque_view_type want;
      if (reset) begin
         expected_views.delete();
         model_head = 0;
         model_fill = 0;
      end else begin
         if (rsp_valid) begin
            results_seen++;
            if (expected_views.size() == 0) begin
               report_mismatch("unexpected result", int'(rsp_status), 0);
            end else begin
               want = expected_views.pop_front();
               if (rsp_front_byte !== want.front)
                  report_mismatch("front_byte", int'(rsp_front_byte), int'(want.front));
               if (rsp_back_byte !== want.back)
                  report_mismatch("back_byte", int'(rsp_back_byte), int'(want.back));
               if (rsp_is_empty !== want.empty)
                  report_mismatch("is_empty", int'(rsp_is_empty), int'(want.empty));
               if (rsp_is_full !== want.full)
                  report_mismatch("is_full", int'(rsp_is_full), int'(want.full));
               if (rsp_status !== want.status)
                  report_mismatch("status", int'(rsp_status), int'(want.status));
            end
         end
         if (start && !busy) begin
            want = apply_deque_op(req_opcode, req_data_byte);
            expected_views.push_back(want);
            items_seen++;
            if (want.status == ST_OVERFLOW)  overflow_seen++;
            if (want.status == ST_UNDERFLOW) underflow_seen++;
            if (want.full)  full_seen++;
            if (want.empty) empty_seen++;
         end
      end
      pending = expected_views.size();
   end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Top of the byte deque bench: drives items into char_deque with random
// gaps, leaves prediction and comparison to deque_checker, and gives the
// verdict once every result is in.
// ----------------------------------------------------------------------------
module tb
   import cdq_pkg::*;
();

   localparam int DEPTH         = 16;
   localparam int RANDOM_ITEMS  = 1880;
   localparam int PHASE_LEN     = 40;    // items per push/pop bias phase
   localparam int DRAIN_EVERY   = 250;   // items between full drains
   localparam int MAX_GAP       = 13;
   localparam int TAIL_CYCLES   = 4;     // result comes in the cycle after accept
   localparam int WATCHDOG_MAX  = 500;   // cycles with no item and no result

   // opcodes outside the enum; the block treats them as no-op
   localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
   localparam logic [2:0] OP_LAST_UNUSED  = 3'd7;

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   logic [2:0] req_opcode;
   logic [7:0] req_data_byte;
   logic       rsp_valid;
   logic [7:0] rsp_front_byte;
   logic [7:0] rsp_back_byte;
   logic       rsp_is_empty;
   logic       rsp_is_full;
   logic [1:0] rsp_status;

   int fail_count;
   int pending;
   int items_seen;
   int results_seen;
   int overflow_seen;
   int underflow_seen;
   int full_seen;
   int empty_seen;
   int idle_cycles;

   char_deque #(.DEPTH(DEPTH)) u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_opcode     (req_opcode),
      .req_data_byte  (req_data_byte),
      .rsp_valid      (rsp_valid),
      .rsp_front_byte (rsp_front_byte),
      .rsp_back_byte  (rsp_back_byte),
      .rsp_is_empty   (rsp_is_empty),
      .rsp_is_full    (rsp_is_full),
      .rsp_status     (rsp_status)
   );

   deque_checker #(.DEPTH(DEPTH)) u_check (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_opcode     (req_opcode),
      .req_data_byte  (req_data_byte),
      .rsp_valid      (rsp_valid),
      .rsp_front_byte (rsp_front_byte),
      .rsp_back_byte  (rsp_back_byte),
      .rsp_is_empty   (rsp_is_empty),
      .rsp_is_full    (rsp_is_full),
      .rsp_status     (rsp_status),
      .fail_count     (fail_count),
      .pending        (pending),
      .items_seen     (items_seen),
      .results_seen   (results_seen),
      .overflow_seen  (overflow_seen),
      .underflow_seen (underflow_seen),
      .full_seen      (full_seen),
      .empty_seen     (empty_seen)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Watchdog: any item accepted or result seen restarts the count.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_MAX) begin
         $display("timeout: no item or result for %0d cycles", idle_cycles);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Send one item after 'gap' idle cycles. Called at the edge where the
   // previous item went in; start only drops when a gap follows, so it is
   // never lowered and raised in the same step.
   task automatic send_item(input logic [2:0] op, input logic [7:0] data,
                            input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start         <= 1'b1;
      req_opcode    <= op;
      req_data_byte <= data;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Hold off until every outstanding result has come back.
   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   initial begin
      int         n;
      int         r;
      int         code;
      int         push_pct;
      bit         no_idle;
      logic [2:0] op;
      logic [7:0] data;

      reset         = 1'b1;
      start         = 1'b0;
      req_opcode    = OP_NOP;
      req_data_byte = 8'h00;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // ---- directed part ----
      // ops on an empty deque: no-op, both pops underflow
      send_item(OP_NOP,       8'hFF, 0);
      send_item(OP_POP_FRONT, 8'h00, $urandom_range(0, MAX_GAP));
      send_item(OP_POP_BACK,  8'hFF, 0);
      // unused opcodes behave as no-op
      for (code = OP_FIRST_UNUSED; code <= OP_LAST_UNUSED; code++)
         send_item(code[2:0], 8'hFF, $urandom_range(0, 2));
      // data extremes at both ends, then pop back down to empty
      send_item(OP_PUSH_FRONT, 8'h00, 0);
      send_item(OP_PUSH_BACK,  8'hFF, 1);
      send_item(OP_POP_FRONT,  8'h5A, 0);
      send_item(OP_POP_BACK,   8'hA5, 0);
      // fill to the brim from both ends, wrapping the head below zero
      for (n = 0; n < DEPTH; n++)
         send_item((n % 2) ? OP_PUSH_BACK : OP_PUSH_FRONT,
                   8'($urandom_range(0, 255)), $urandom_range(0, 3));
      // pushes into a full deque get dropped with overflow
      send_item(OP_PUSH_FRONT, 8'h00, 0);
      send_item(OP_PUSH_BACK,  8'hFF, 0);
      drain_results();

      // ---- random part ----
      // Phases bias push vs pop so the deque sweeps between empty and full,
      // with the index wrapping both ways; a few percent is noise opcodes.
      push_pct = 50;
      no_idle  = 1'b0;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % PHASE_LEN == 0) begin
            case ($urandom_range(0, 2))
               0:       push_pct = 80;
               1:       push_pct = 20;
               default: push_pct = 50;
            endcase
            no_idle = ($urandom_range(0, 3) == 0);
         end
         if (n > 0 && n % DRAIN_EVERY == 0) drain_results();

         r = $urandom_range(0, 99);
         if (r < 6) begin
            if ($urandom_range(0, 1)) op = OP_NOP;
            else op = 3'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
         end else if ($urandom_range(0, 99) < push_pct) begin
            op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
         end else begin
            op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
         end
         data = 8'($urandom_range(0, 255));
         send_item(op, data, no_idle ? 0 : $urandom_range(0, MAX_GAP));
      end

      // ---- wind down ----
      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d items, %0d results checked", items_seen, results_seen);
      $display("overflows %0d, underflows %0d, full %0d, empty %0d",
               overflow_seen, underflow_seen, full_seen, empty_seen);
      if (pending != 0)
         $display("%0d expected result(s) never arrived", pending);
      if (fail_count == 0 && pending == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
